/* hdl/x87eds_pkg.sv */
//------------------------------------------------------------------------------
// x87eds_pkg
// Shared types and constants for the extended/double load-store block.
//------------------------------------------------------------------------------
`default_nettype none
package x87eds_pkg;
  localparam int unsigned StackDepth = 8;
  localparam logic [14:0] ExtBias   = 15'd16383;
  localparam logic [14:0] ExtExpMax = 15'h7fff;
  localparam logic [10:0] DblExpMax = 11'h7ff;
  localparam logic [15:0] SignBit   = 16'h8000;
  localparam logic       CmdLoad  = 1'b0;
  localparam logic       CmdStore = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [63:0] sig;
    logic [15:0] se;
  } item_t;

  typedef struct packed {
    logic [63:0] out_sig;
    logic [15:0] out_se;
    logic [63:0] dbl;
    logic [2:0]  top;
  } result_t;
endpackage
`default_nettype wire

/* hdl/x87eds_ext2dbl.sv */
//------------------------------------------------------------------------------
// x87eds_ext2dbl
// Converts an 80-bit extended value to a double bit pattern (round to even).
//------------------------------------------------------------------------------
`default_nettype none
module x87eds_ext2dbl
  import x87eds_pkg::*;
(
  input  wire logic [63:0] sig_i,
  input  wire logic [15:0] se_i,
  output logic      [63:0] dbl_o
);
  logic        sgn;
  logic [14:0] ex;
  logic [5:0]  lz;
  logic [63:0] norm;
  logic [53:0] keep;
  logic [10:0] rest;
  logic        rnd;
  logic signed [17:0] dexp;

  always_comb begin
    sgn  = se_i[15];
    ex   = se_i[14:0];
    lz   = '0;
    for (int i = 0; i < 64; i++) begin
      if (sig_i[i]) lz = 6'(63 - i);
    end
    norm = sig_i << lz;
    rest = norm[10:0];
    rnd  = (rest > 11'h400) || (rest == 11'h400 && norm[11]);
    keep = {1'b0, norm[63:11]} + 54'(rnd);
    dexp = 18'(signed'({3'b0, ex})) - 18'(signed'({3'b0, ExtBias})) + 18'sd1023
           - 18'(signed'({12'b0, lz})) + 18'(signed'({17'b0, keep[53]}));
    if (sig_i == '0) begin
      dbl_o = (ex == '0) ? '0 : {sgn, 63'b0};
    end else if (dexp <= 0) begin
      dbl_o = {sgn, 63'b0};
    end else if (dexp >= 18'(signed'({7'b0, DblExpMax}))) begin
      dbl_o = {sgn, DblExpMax, 52'b0};
    end else begin
      dbl_o = {sgn, dexp[10:0], keep[53] ? keep[52:1] : keep[51:0]};
    end
  end
endmodule
`default_nettype wire

/* hdl/x87eds_dbl2ext.sv */
//------------------------------------------------------------------------------
// x87eds_dbl2ext
// Expands a double bit pattern to its 80-bit extended image.
//------------------------------------------------------------------------------
`default_nettype none
module x87eds_dbl2ext
  import x87eds_pkg::*;
(
  input  wire logic [63:0] dbl_i,
  output logic      [63:0] sig_o,
  output logic      [15:0] se_o
);
  logic [10:0] dex;
  always_comb begin
    dex = dbl_i[62:52];
    sig_o = {1'b1, dbl_i[51:0], 11'b0};
    if (dex == '0) begin
      sig_o = '0;
      se_o  = dbl_i[63] ? SignBit : 16'h0;
    end else if (dex == DblExpMax) begin
      se_o = {dbl_i[63], ExtExpMax};
    end else begin
      se_o = {dbl_i[63], 15'({4'b0, dex} + 15'd15360)};
    end
  end
endmodule
`default_nettype wire

/* hdl/x87_extended_double_load_store.sv */
//------------------------------------------------------------------------------
// x87_extended_double_load_store
// Eight-entry double register stack with extended load/store conversion.
//------------------------------------------------------------------------------
// One item per cycle while the output is not stalled: an item is captured in
// an input register, then converted and applied to the stack as it advances,
// and its result lands in an output register. The stack and top index update
// as each item leaves the input register, so back-to-back items see it.
`default_nettype none
module x87_extended_double_load_store
  import x87eds_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [79:0]  s_axis_tdata_i,  // mem_significand[63:0], mem_sign_exponent[79:64]
  input  wire logic         s_axis_tuser_i,  // cmd
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic      [151:0] m_axis_tdata_o   // out_significand[63:0], out_sign_exponent[79:64],
                                             // double_bits[143:80], new_top[146:144]
);
  logic        in_vld_q, out_vld_q;
  item_t       in_q;
  result_t     res_q, res_d;
  logic [63:0] stk_q [StackDepth];
  logic [2:0]  top_q, top_d;
  logic [63:0] ld_dbl, st_sig;
  logic [15:0] st_se;
  logic        adv;

  assign adv = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || adv;

  x87eds_ext2dbl u_e2d (.sig_i(in_q.sig), .se_i(in_q.se), .dbl_o(ld_dbl));
  x87eds_dbl2ext u_d2e (.dbl_i(stk_q[top_q]), .sig_o(st_sig), .se_o(st_se));

  always_comb begin
    if (in_q.cmd == CmdLoad) begin
      top_d = top_q - 3'd1;
      res_d = '{out_sig: '0, out_se: '0, dbl: ld_dbl, top: top_d};
    end else begin
      top_d = top_q + 3'd1;
      res_d = '{out_sig: st_sig, out_se: st_se, dbl: stk_q[top_q], top: top_d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      top_q     <= '0;
      for (int i = 0; i < StackDepth; i++) stk_q[i] <= '0;
    end else begin
      if (s_axis_tready_o) in_vld_q <= s_axis_tvalid_i;
      if (adv) begin
        out_vld_q <= 1'b1;
        top_q     <= top_d;
        if (in_q.cmd == CmdLoad) stk_q[top_d] <= ld_dbl;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i)
      in_q <= '{cmd: s_axis_tuser_i, sig: s_axis_tdata_i[63:0], se: s_axis_tdata_i[79:64]};
    if (adv) res_q <= res_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {5'b0, res_q.top, res_q.dbl, res_q.out_se, res_q.out_sig};
endmodule
`default_nettype wire

/* tb/x87_extended_double_load_store_tb.sv */
//------------------------------------------------------------------------------
// x87_extended_double_load_store_tb
// Checks the extended/double load-store stack against a cycle-free predictor.
// Directed corner loads and stores run first, then random push/pop mixes;
// both stream sides insert random gaps and stalls.
//------------------------------------------------------------------------------
module x87_extended_double_load_store_tb;
  import x87eds_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [79:0]  s_axis_tdata_i = '0;  // mem_significand[63:0], mem_sign_exponent[79:64]
  logic         s_axis_tuser_i = 1'b0; // cmd
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [151:0] m_axis_tdata_o;       // out_significand[63:0], out_sign_exponent[79:64],
                                      // double_bits[143:80], new_top[146:144]

  x87_extended_double_load_store DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  item_t   pending_q[$];
  result_t expected_q[$];
  logic [63:0] fp_stack[8];
  logic [2:0]  fp_top;
  int errors = 0;
  int n_loads = 0, n_stores = 0, n_checked = 0;
  longint cycles = 0;
  bit stim_done = 1'b0;

  function automatic logic [63:0] extended_to_double(logic [63:0] m, logic [15:0] se);
    logic [63:0] sgn, norm, keep;
    logic [10:0] rest;
    int lz, dexp;
    sgn = {se[15], 63'b0};
    if (m == 0 && se[14:0] == 0) return 64'b0;
    if (m == 0) return sgn;
    norm = m;
    lz = 0;
    while (!norm[63]) begin
      norm = norm << 1;
      lz++;
    end
    keep = norm >> 11;
    rest = norm[10:0];
    if (rest > 11'h400 || (rest == 11'h400 && keep[0])) keep = keep + 1;
    dexp = int'(se[14:0]) - int'(ExtBias) + 1023 - lz;
    if (keep[53]) begin
      keep = keep >> 1;
      dexp++;
    end
    if (dexp <= 0) return sgn;
    if (dexp >= int'(DblExpMax)) return sgn | {1'b0, DblExpMax, 52'b0};
    return sgn | {1'b0, dexp[10:0], keep[51:0]};
  endfunction

  function automatic result_t apply_request(item_t it);
    result_t r;
    logic [63:0] v;
    logic [10:0] dex;
    r = '0;
    if (it.cmd == CmdLoad) begin
      v = extended_to_double(it.sig, it.se);
      fp_top = fp_top - 3'd1;
      fp_stack[fp_top] = v;
      n_loads++;
    end else begin
      v = fp_stack[fp_top];
      fp_top = fp_top + 3'd1;
      dex = v[62:52];
      if (dex == 0) begin
        r.out_sig = '0;
        r.out_se = v[63] ? SignBit : 16'h0;
      end else begin
        r.out_sig = {1'b1, v[51:0], 11'b0};
        // 15360 = 16383 - 1023
        r.out_se = {v[63], (dex == DblExpMax) ? ExtExpMax : 15'(dex + 15'd15360)};
      end
      n_stores++;
    end
    r.dbl = v;
    r.top = fp_top;
    return r;
  endfunction

  // driver
  int  src_gap = 0;
  always @(posedge clk_i) begin
    item_t it;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        it.cmd = s_axis_tuser_i;
        it.se = s_axis_tdata_i[79:64];
        it.sig = s_axis_tdata_i[63:0];
        expected_q.push_back(apply_request(it));
        src_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
      end
      if (!(s_axis_tvalid_i && !s_axis_tready_o)) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          it = pending_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i <= it.cmd;
          s_axis_tdata_i <= {it.se, it.sig};
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  int sink_gap = 0;
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni) begin
      cycles++;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.out_sig = m_axis_tdata_o[63:0];
        got.out_se = m_axis_tdata_o[79:64];
        got.dbl = m_axis_tdata_o[143:80];
        got.top = m_axis_tdata_o[146:144];
        if (expected_q.size() == 0) begin
          $error("unexpected result %h", m_axis_tdata_o);
          errors++;
        end else begin
          want = expected_q.pop_front();
          n_checked++;
          if (got.out_sig !== want.out_sig) begin
            $error("out_significand exp %h got %h", want.out_sig, got.out_sig);
            errors++;
          end
          if (got.out_se !== want.out_se) begin
            $error("out_sign_exponent exp %h got %h", want.out_se, got.out_se);
            errors++;
          end
          if (got.dbl !== want.dbl) begin
            $error("double_bits exp %h got %h", want.dbl, got.dbl);
            errors++;
          end
          if (got.top !== want.top) begin
            $error("new_top exp %h got %h", want.top, got.top);
            errors++;
          end
        end
        sink_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic add_load(logic [63:0] m, logic [15:0] se);
    item_t it;
    it.cmd = CmdLoad;
    it.sig = m;
    it.se = se;
    pending_q.push_back(it);
  endtask

  task automatic add_store();
    item_t it;
    it.cmd = CmdStore;
    it.sig = rand64();
    it.se = 16'($urandom());
    pending_q.push_back(it);
  endtask

  // random extended value biased toward the interesting exponent bands
  function automatic logic [79:0] rand_extended();
    logic [63:0] m;
    logic [14:0] e;
    logic [15:0] se;
    m = rand64();
    case ($urandom_range(0, 9))
      0: m = m >> $urandom_range(1, 63);
      1: m = {m[63:11], 11'h400};
      2: m = {m[63:11], 11'h7ff} | 64'hffff_ffff_ffff_f800;
      3: m = 64'h0;
      default: m[63] = 1'b1;
    endcase
    case ($urandom_range(0, 5))
      0: e = 15'($urandom());
      1: e = 15'($urandom_range(16383 - 1023 - 70, 16383 - 1023 + 5));
      2: e = 15'($urandom_range(16383 + 1020, 16383 + 1030));
      3: e = ExtExpMax - 15'($urandom_range(0, 1));
      default: e = 15'($urandom_range(16383 - 1000, 16383 + 1000));
    endcase
    se = {1'($urandom()), e};
    return {se, m};
  endfunction

  initial begin
    logic [79:0] x;
    int depth;
    for (int i = 0; i < 8; i++) fp_stack[i] = '0;
    fp_top = '0;
    // directed corners
    add_store();                                    // pop the reset zero
    add_load(64'h0, 16'h8000);                      // exact zero, sign dropped
    add_load(64'h0, 16'hc000);                      // zero significand, signed zero
    add_load(64'hffff_ffff_ffff_ffff, 16'h3fff);    // rounding carry
    add_load(64'h8000_0000_0000_0400, 16'h3fff);    // tie, even stays
    add_load(64'h8000_0000_0000_0c00, 16'hbfff);    // tie, odd rounds up
    add_load(64'h8000_0000_0000_0000, 16'h3c00);    // underflow edge
    add_load(64'h0000_0000_0000_0001, 16'h7ffe);    // deep normalize
    add_load(64'hc000_0000_0000_0000, 16'hffff);    // extended NaN
    add_load(64'h8000_0000_0000_0000, 16'h43ff);    // overflow
    repeat (9) add_store();                         // wrap and pop inf/zero
    add_load(64'h8000_0000_0000_0001, 16'h3c01);    // smallest double normal
    add_load(64'hffff_ffff_ffff_f800, 16'h43fe);    // largest finite
    add_store();
    add_store();
    // random: runs of pushes then pops, plus noise
    depth = 0;
    while (pending_q.size() < 1770) begin
      if ($urandom_range(0, 5) == 0) begin
        if ($urandom_range(0, 1)) add_store();
        else begin
          x = rand_extended();
          add_load(x[63:0], x[79:64]);
        end
      end else if (depth < 8 && (depth == 0 || $urandom_range(0, 1))) begin
        x = rand_extended();
        add_load(x[63:0], x[79:64]);
        depth++;
      end else begin
        add_store();
        depth--;
      end
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0 && !s_axis_tvalid_i && expected_q.size() == 0);
    repeat (10) @(posedge clk_i);
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done || cycles > 500000);
    if (!stim_done) begin
      $display("tb: failure");
    end else begin
      $display("covered %0d loads and %0d stores, %0d results checked",
               n_loads, n_stores, n_checked);
      if (errors == 0 && expected_q.size() == 0) begin
        $display("tb: success");
      end else begin
        $display("tb: failure");
      end
    end
    $finish;
  end
endmodule
